### hdl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, result codes and helper functions for the JSON string
// unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int MaxResults = 4;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
    localparam logic [2:0] ERR_BAD_ESC  = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd3;
    localparam logic [2:0] ERR_UNTERM   = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] err;
    } t_res;

    // results of one input byte
    typedef struct packed {
        logic [2:0]                  cnt;
        t_res [MaxResults-1:0]       res;
    } t_step;

    typedef struct packed {
        logic [2:0]       cnt;
        logic [3:0][7:0]  b;
    } t_utf8;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } t_lookup;

    function automatic t_utf8 utf8_enc(input logic [20:0] c);
        t_utf8 u;
        u = '0;
        if (c < 21'h80) begin
            u.cnt  = 3'd1;
            u.b[0] = c[7:0];
        end else if (c < 21'h800) begin
            u.cnt  = 3'd2;
            u.b[0] = {3'b110, c[10:6]};
            u.b[1] = {2'b10, c[5:0]};
        end else if (c < 21'h10000) begin
            u.cnt  = 3'd3;
            u.b[0] = {4'b1110, c[15:12]};
            u.b[1] = {2'b10, c[11:6]};
            u.b[2] = {2'b10, c[5:0]};
        end else begin
            u.cnt  = 3'd4;
            u.b[0] = {5'b11110, c[20:18]};
            u.b[1] = {2'b10, c[17:12]};
            u.b[2] = {2'b10, c[11:6]};
            u.b[3] = {2'b10, c[5:0]};
        end
        return u;
    endfunction

    function automatic t_lookup hex_val(input logic [7:0] b);
        t_lookup h;
        h = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.ok    = 1'b1;
            h.value = b - 8'h30;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.ok    = 1'b1;
            h.value = b - 8'h57;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.ok    = 1'b1;
            h.value = b - 8'h37;
        end
        return h;
    endfunction

    function automatic t_lookup simple_esc(input logic [7:0] b);
        t_lookup e;
        e.ok = 1'b1;
        case (b)
            8'h22:   e.value = 8'h22;
            8'h5C:   e.value = 8'h5C;
            8'h2F:   e.value = 8'h2F;
            8'h62:   e.value = 8'h08;
            8'h66:   e.value = 8'h0C;
            8'h6E:   e.value = 8'h0A;
            8'h72:   e.value = 8'h0D;
            8'h74:   e.value = 8'h09;
            default: begin
                e.ok    = 1'b0;
                e.value = 8'h00;
            end
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

### hdl/jsu_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_decode
// Escape decoder: parse state plus the one-byte step that yields up to four
// results.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_text_byte,
    input  wire logic            i_end_of_text,
    output jsu_pkg::t_step       o_step
);

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_STR     = 4'd1,
        M_ESC     = 4'd2,
        M_HEX0    = 4'd3,
        M_HEX1    = 4'd4,
        M_HEX2    = 4'd5,
        M_HEX3    = 4'd6,
        M_PAIR    = 4'd7,
        M_PAIR_BS = 4'd8,
        M_LOW0    = 4'd9,
        M_LOW1    = 4'd10,
        M_LOW2    = 4'd11,
        M_LOW3    = 4'd12
    } t_mode;

    t_mode        r_mode, n_mode;
    logic [15:0]  r_acc, n_acc;
    logic [15:0]  r_high, n_high;

    jsu_pkg::t_step   st;
    jsu_pkg::t_utf8   u_high, u_cp;
    jsu_pkg::t_lookup hx, esc;
    logic [15:0]      acc_new;
    logic [20:0]      pair_cp;
    logic [2:0]       err;
    logic             in_hex;

    always_comb begin
        hx      = jsu_pkg::hex_val(i_text_byte);
        esc     = jsu_pkg::simple_esc(i_text_byte);
        acc_new = {r_acc[11:0], hx.value[3:0]};
        pair_cp = 21'h10000 + {1'b0, r_high[9:0], 10'b0} + {5'b0, acc_new} - 21'h0DC00;
        u_high  = jsu_pkg::utf8_enc({5'b0, r_high});
        u_cp    = jsu_pkg::utf8_enc((r_mode == M_LOW3) ? pair_cp : {5'b0, acc_new});

        st     = '0;
        err    = jsu_pkg::ERR_NONE;
        n_mode = r_mode;
        n_acc  = r_acc;
        n_high = r_high;

        unique case (r_mode)
            M_IDLE: begin
                if (i_text_byte == 8'h22) n_mode = M_STR;
                else err = jsu_pkg::ERR_NO_QUOTE;
            end
            M_STR: begin
                if (i_text_byte == 8'h22) begin
                    st.cnt         = 3'd1;
                    st.res[0].kind = jsu_pkg::KIND_CLOSE;
                    n_mode         = M_IDLE;
                end else if (i_text_byte == 8'h5C) begin
                    n_mode = M_ESC;
                end else begin
                    st.cnt         = 3'd1;
                    st.res[0].data = i_text_byte;
                end
            end
            M_ESC: begin
                if (i_text_byte == 8'h75) begin
                    n_acc  = '0;
                    n_mode = M_HEX0;
                end else if (esc.ok) begin
                    st.cnt         = 3'd1;
                    st.res[0].data = esc.value;
                    n_mode         = M_STR;
                end else begin
                    err = jsu_pkg::ERR_BAD_ESC;
                end
            end
            M_PAIR: begin
                if (i_text_byte == 8'h5C) begin
                    n_mode = M_PAIR_BS;
                end else begin
                    // held high surrogate always encodes as three bytes
                    st.cnt         = 3'd4;
                    st.res[0].data = u_high.b[0];
                    st.res[1].data = u_high.b[1];
                    st.res[2].data = u_high.b[2];
                    if (i_text_byte == 8'h22) begin
                        st.res[3].kind = jsu_pkg::KIND_CLOSE;
                        n_mode         = M_IDLE;
                    end else begin
                        st.res[3].data = i_text_byte;
                        n_mode         = M_STR;
                    end
                end
            end
            M_PAIR_BS: begin
                if (i_text_byte == 8'h75) begin
                    n_acc  = '0;
                    n_mode = M_LOW0;
                end else if (esc.ok) begin
                    st.cnt         = 3'd4;
                    st.res[0].data = u_high.b[0];
                    st.res[1].data = u_high.b[1];
                    st.res[2].data = u_high.b[2];
                    st.res[3].data = esc.value;
                    n_mode         = M_STR;
                end else begin
                    err = jsu_pkg::ERR_BAD_ESC;
                end
            end
            M_HEX0, M_HEX1, M_HEX2, M_HEX3, M_LOW0, M_LOW1, M_LOW2, M_LOW3: begin
                if (!hx.ok) begin
                    err = jsu_pkg::ERR_BAD_HEX;
                end else begin
                    n_acc = acc_new;
                    if (r_mode == M_HEX3 && acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                        n_high = acc_new;
                        n_mode = M_PAIR;
                    end else if (r_mode == M_HEX3 || r_mode == M_LOW3) begin
                        st.cnt         = u_cp.cnt;
                        st.res[0].data = u_cp.b[0];
                        st.res[1].data = u_cp.b[1];
                        st.res[2].data = u_cp.b[2];
                        st.res[3].data = u_cp.b[3];
                        n_mode         = M_STR;
                    end else begin
                        n_mode = t_mode'(r_mode + 4'd1);
                    end
                end
            end
            default: begin
                n_mode = M_IDLE;
            end
        endcase

        in_hex = (n_mode >= M_HEX0 && n_mode <= M_HEX3) ||
                 (n_mode >= M_LOW0 && n_mode <= M_LOW3);
        if (err == jsu_pkg::ERR_NONE && i_end_of_text && n_mode != M_IDLE) begin
            err = in_hex ? jsu_pkg::ERR_BAD_HEX : jsu_pkg::ERR_UNTERM;
        end

        // an error voids the whole step
        if (err != jsu_pkg::ERR_NONE) begin
            st             = '0;
            st.cnt         = 3'd1;
            st.res[0].kind = jsu_pkg::KIND_ERROR;
            st.res[0].err  = err;
            n_mode         = M_IDLE;
            n_acc          = '0;
            n_high         = '0;
        end
    end

    assign o_step = st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc  <= '0;
            r_high <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_high <= n_high;
        end
    end

endmodule
`default_nettype wire

### hdl/jsu_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_out_buf
// Result register: holds the results of one byte and hands them out one
// beat at a time.
// ----------------------------------------------------------------------------
module jsu_out_buf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire jsu_pkg::t_step  i_step,
    output logic                 o_free,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [7:0]           o_out_byte,
    output logic [1:0]           o_kind,
    output logic [2:0]           o_error_code,
    output logic                 o_last_of_run
);

    jsu_pkg::t_res [jsu_pkg::MaxResults-1:0] r_res;
    logic [2:0]                              r_cnt;
    logic [1:0]                              r_idx;
    logic                                    last_beat;
    logic                                    take;

    assign last_beat     = ({1'b0, r_idx} == (r_cnt - 3'd1));
    assign take          = o_valid && !i_stall;
    assign o_valid       = (r_cnt != 3'd0);
    assign o_free        = !o_valid || (take && last_beat);
    assign o_out_byte    = r_res[r_idx].data;
    assign o_kind        = r_res[r_idx].kind;
    assign o_error_code  = r_res[r_idx].err;
    assign o_last_of_run = last_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load && o_free) begin
            r_cnt <= i_step.cnt;
            r_idx <= '0;
        end else if (take) begin
            if (last_beat) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_step.res;
        end
    end

endmodule
`default_nettype wire

### hdl/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a JSON string literal byte by byte into UTF-8 output beats, with
// end and error markers.
// ----------------------------------------------------------------------------
// Takes one source byte per clock unless o_stall is high. Each byte sits in
// an input register, is decoded combinationally and its results (zero to
// four beats) are loaded into a result register that hands them out one beat
// per clock unless i_stall is high. A byte that yields at most one beat leaves
// at full rate; a byte that yields more holds the input until its last beat is
// taken. A byte passes the input register, then the result register.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_kind,
    output logic [2:0]       o_error_code,
    output logic             o_last_of_run
);

    logic            r_in_valid;
    logic [7:0]      r_text_byte;
    logic            r_eot;
    logic            buf_free;
    logic            adv;
    logic            accept;
    jsu_pkg::t_step  step;

    assign adv     = r_in_valid && buf_free;
    assign o_stall = r_in_valid && !buf_free;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_text_byte <= i_text_byte;
            r_eot       <= i_end_of_text;
        end
    end

    jsu_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (adv),
        .i_text_byte   (r_text_byte),
        .i_end_of_text (r_eot),
        .o_step        (step)
    );

    jsu_out_buf u_out_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (adv),
        .i_step        (step),
        .o_free        (buf_free),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_kind        (o_kind),
        .o_error_code  (o_error_code),
        .o_last_of_run (o_last_of_run)
    );

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON string unescaper. Source bytes go in over a
// valid/stall channel, and a cycle-free model of the literal parser predicts
// every output beat. A short table of edge cases opens the run. Random literals
// follow, built from plain bytes, escapes, \u units and surrogate pairs, with a
// few broken literals mixed in. Both sides idle at random, and once the output
// is held off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;

    localparam int          RandomBytes = 345;
    localparam logic [7:0]  CH_QUOTE    = 8'h22;
    localparam logic [7:0]  CH_BSLASH   = 8'h5C;
    localparam logic [7:0]  CH_U        = 8'h75;

    typedef enum logic [3:0] {
        PM_IDLE    = 4'd0,
        PM_STR     = 4'd1,
        PM_ESC     = 4'd2,
        PM_HEX0    = 4'd3,
        PM_HEX1    = 4'd4,
        PM_HEX2    = 4'd5,
        PM_HEX3    = 4'd6,
        PM_PAIR    = 4'd7,
        PM_PAIR_BS = 4'd8,
        PM_LOW0    = 4'd9,
        PM_LOW1    = 4'd10,
        PM_LOW2    = 4'd11,
        PM_LOW3    = 4'd12
    } t_parse_mode;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] err;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic [7:0] text;
        logic       eot;
        logic       typed;
        logic [1:0] kind;
        logic [2:0] err;
        logic [7:0] data;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_text_byte;
    logic        i_end_of_text;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_kind;
    logic [2:0]  o_error_code;
    logic        o_last_of_run;

    json_string_unescape_utf8 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_kind        (o_kind),
        .o_error_code  (o_error_code),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [7:0] esc_char  [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
    logic [7:0] esc_value [8] = '{8'h22, 8'h5C, 8'h2F, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09};

    // edge cases; rows with typed set carry their single beat
    t_row dir_rows [25] = '{
        '{"A",       1'b0, 1'b1, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_NO_QUOTE, 8'h00},
        '{CH_QUOTE,  1'b1, 1'b1, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERM,   8'h00},
        '{CH_QUOTE,  1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{8'h00,     1'b0, 1'b1, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{8'hFF,     1'b0, 1'b1, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'hFF},
        '{CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{CH_QUOTE,  1'b0, 1'b1, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h22},
        '{CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{CH_U,      1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{"D",       1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{"b",       1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{"F",       1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{"f",       1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{CH_U,      1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{"F",       1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{"f",       1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{"F",       1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{"F",       1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{CH_U,      1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{"0",       1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{"x",       1'b0, 1'b1, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_HEX,  8'h00},
        '{CH_QUOTE,  1'b0, 1'b0, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE,     8'h00},
        '{CH_QUOTE,  1'b1, 1'b1, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE,     8'h00}
    };

    t_parse_mode str_state = PM_IDLE;
    logic [15:0] hex_acc   = '0;
    logic [15:0] held_high = '0;
    t_beat       step_beats [$];
    t_beat       expected_beats [$];

    bit burst     = 1'b0;
    int hold_req  = 0;
    int bytes_sent   = 0;
    int beats_seen   = 0;
    int close_beats  = 0;
    int error_beats  = 0;
    int mismatches   = 0;
    int stall_cycles = 0;
    int err_count [5] = '{0, 0, 0, 0, 0};

    function automatic t_beat mk_beat(input logic [7:0] d, input logic [1:0] k,
                                      input logic [2:0] e);
        t_beat x;
        x.data = d;
        x.kind = k;
        x.err  = e;
        x.last = 1'b0;
        return x;
    endfunction

    task automatic add_beat(input t_beat x);
        step_beats.insert(step_beats.size(), x);
    endtask

    function automatic int hex_of(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - 48;
        if (b >= "a" && b <= "f") return int'(b) - 87;
        if (b >= "A" && b <= "F") return int'(b) - 55;
        return -1;
    endfunction

    function automatic int esc_value_of(input logic [7:0] b);
        for (int k = 0; k < 8; k++) begin
            if (esc_char[k] == b) return int'(esc_value[k]);
        end
        return -1;
    endfunction

    task automatic emit_code_point(input logic [31:0] c);
        logic [31:0] lead;
        if (c < 32'h80) begin
            add_beat(mk_beat(c[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
        end else if (c < 32'h800) begin
            lead = 32'hC0 | (c >> 6);
            add_beat(mk_beat(lead[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
            add_beat(mk_beat({2'b10, c[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
        end else if (c < 32'h10000) begin
            lead = 32'hE0 | (c >> 12);
            add_beat(mk_beat(lead[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
            add_beat(mk_beat({2'b10, c[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
            add_beat(mk_beat({2'b10, c[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
        end else begin
            lead = 32'hF0 | (c >> 18);
            add_beat(mk_beat(lead[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
            add_beat(mk_beat({2'b10, c[17:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
            add_beat(mk_beat({2'b10, c[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
            add_beat(mk_beat({2'b10, c[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
        end
    endtask

    // Advances the literal parser by one source byte; fills step_beats.
    task automatic decode_byte(input logic [7:0] b, input logic eot);
        logic [2:0]  err;
        int          d;
        logic [31:0] cp;
        bit          in_hex;
        step_beats.delete();
        err = jsu_pkg::ERR_NONE;
        case (str_state)
            PM_IDLE: begin
                if (b == CH_QUOTE) str_state = PM_STR;
                else err = jsu_pkg::ERR_NO_QUOTE;
            end
            PM_STR: begin
                if (b == CH_QUOTE) begin
                    add_beat(mk_beat(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE));
                    str_state = PM_IDLE;
                end else if (b == CH_BSLASH) begin
                    str_state = PM_ESC;
                end else begin
                    add_beat(mk_beat(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
                end
            end
            PM_ESC: begin
                d = esc_value_of(b);
                if (b == CH_U) begin
                    hex_acc = '0;
                    str_state = PM_HEX0;
                end else if (d < 0) begin
                    err = jsu_pkg::ERR_BAD_ESC;
                end else begin
                    add_beat(mk_beat(d[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
                    str_state = PM_STR;
                end
            end
            PM_PAIR: begin
                if (b == CH_BSLASH) begin
                    str_state = PM_PAIR_BS;
                end else begin
                    emit_code_point({16'h0, held_high});
                    if (b == CH_QUOTE) begin
                        add_beat(mk_beat(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE));
                        str_state = PM_IDLE;
                    end else begin
                        add_beat(mk_beat(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
                        str_state = PM_STR;
                    end
                end
            end
            PM_PAIR_BS: begin
                d = esc_value_of(b);
                if (b == CH_U) begin
                    hex_acc = '0;
                    str_state = PM_LOW0;
                end else begin
                    emit_code_point({16'h0, held_high});
                    if (d < 0) begin
                        err = jsu_pkg::ERR_BAD_ESC;
                    end else begin
                        add_beat(mk_beat(d[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE));
                        str_state = PM_STR;
                    end
                end
            end
            default: begin
                d = hex_of(b);
                if (d < 0) begin
                    err = jsu_pkg::ERR_BAD_HEX;
                end else begin
                    hex_acc = {hex_acc[11:0], d[3:0]};
                    if (str_state == PM_HEX3) begin
                        if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                            held_high = hex_acc;
                            str_state = PM_PAIR;
                        end else begin
                            emit_code_point({16'h0, hex_acc});
                            str_state = PM_STR;
                        end
                    end else if (str_state == PM_LOW3) begin
                        cp = 32'h10000 + (({16'h0, held_high} - 32'hD800) << 10)
                             + ({16'h0, hex_acc} - 32'hDC00);
                        emit_code_point(cp);
                        str_state = PM_STR;
                    end else begin
                        str_state = t_parse_mode'(str_state + 4'd1);
                    end
                end
            end
        endcase

        if (err == jsu_pkg::ERR_NONE && eot && str_state != PM_IDLE) begin
            in_hex = (str_state >= PM_HEX0 && str_state <= PM_HEX3) ||
                     (str_state >= PM_LOW0 && str_state <= PM_LOW3);
            err = in_hex ? jsu_pkg::ERR_BAD_HEX : jsu_pkg::ERR_UNTERM;
        end
        if (err != jsu_pkg::ERR_NONE) begin
            step_beats.delete();
            add_beat(mk_beat(8'h00, jsu_pkg::KIND_ERROR, err));
            str_state = PM_IDLE;
            hex_acc   = '0;
            held_high = '0;
        end
        if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic offer_byte(input logic [7:0] b, input logic eot, input bit typed,
                              input t_beat typed_beat);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        decode_byte(b, eot);
        if (typed) begin
            typed_beat.last = 1'b1;
            expected_beats.insert(expected_beats.size(), typed_beat);
        end else begin
            foreach (step_beats[k]) expected_beats.insert(expected_beats.size(), step_beats[k]);
        end
        bytes_sent++;
    endtask

    task automatic put_byte(input logic [7:0] b, input logic eot);
        offer_byte(b, eot, 1'b0, '0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] non_escape_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_U || esc_value_of(b) >= 0);
        return b;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (hex_of(b) >= 0);
        return b;
    endfunction

    // \uXXXX; a cut of 0..3 stops after that many digits with end of text
    task automatic send_hex_unit(input logic [15:0] u, input int cut);
        logic [7:0] chars [6];
        chars[0] = CH_BSLASH;
        chars[1] = CH_U;
        for (int k = 0; k < 4; k++) chars[2 + k] = hex_char(u[15 - 4 * k -: 4]);
        if (cut < 0) begin
            for (int k = 0; k < 6; k++) put_byte(chars[k], 1'b0);
        end else begin
            for (int k = 0; k < 2 + cut; k++) put_byte(chars[k], k == 1 + cut);
        end
    endtask

    task automatic random_literal();
        int         pieces;
        int         pick;
        bit         ended;
        logic [15:0] u;
        burst = ($urandom_range(0, 3) == 0);
        ended = 1'b0;
        if ($urandom_range(0, 15) == 0) put_byte(plain_byte(), 1'b0);
        put_byte(CH_QUOTE, 1'b0);
        pieces = $urandom_range(0, 10);
        for (int p = 0; p < pieces && !ended; p++) begin
            pick = $urandom_range(0, 29);
            if (pick < 14) begin
                put_byte(plain_byte(), 1'b0);
            end else if (pick < 19) begin
                put_byte(CH_BSLASH, 1'b0);
                put_byte(esc_char[$urandom_range(0, 7)], 1'b0);
            end else if (pick < 23) begin
                case (pick)
                    19:      u = 16'($urandom_range(0, 16'h7F));
                    20:      u = 16'($urandom_range(16'h80, 16'h7FF));
                    21:      u = 16'($urandom_range(16'hDC00, 16'hDFFF));
                    default: u = 16'($urandom());
                endcase
                send_hex_unit(u, -1);
            end else if (pick < 27) begin
                u = 16'($urandom_range(16'hD800, 16'hDBFF));
                send_hex_unit(u, -1);
                if ($urandom_range(0, 3) != 0) u = 16'($urandom_range(16'hDC00, 16'hDFFF));
                else u = 16'($urandom());
                send_hex_unit(u, -1);
            end else if (pick < 29) begin
                u = 16'($urandom_range(16'hD800, 16'hDBFF));
                send_hex_unit(u, -1);
                case ($urandom_range(0, 2))
                    0: put_byte(plain_byte(), 1'b0);
                    1: begin
                        put_byte(CH_BSLASH, 1'b0);
                        put_byte(esc_char[$urandom_range(0, 7)], 1'b0);
                    end
                    default: ;
                endcase
            end else begin
                ended = 1'b1;
                case ($urandom_range(0, 4))
                    0: begin
                        put_byte(CH_BSLASH, 1'b0);
                        put_byte(non_escape_byte(), 1'b0);
                    end
                    1: begin
                        put_byte(CH_BSLASH, 1'b0);
                        put_byte(CH_U, 1'b0);
                        repeat ($urandom_range(0, 3))
                            put_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
                        put_byte(non_hex_byte(), 1'b0);
                    end
                    2: send_hex_unit(16'($urandom()), $urandom_range(0, 3));
                    3: put_byte(plain_byte(), 1'b1);
                    default: begin
                        send_hex_unit(16'($urandom_range(16'hD800, 16'hDBFF)), -1);
                        put_byte(CH_BSLASH, 1'b0);
                        put_byte(non_escape_byte(), 1'b0);
                    end
                endcase
            end
        end
        if (!ended) put_byte(CH_QUOTE, $urandom_range(0, 3) == 0);
    endtask

    task automatic check_beat();
        t_beat want;
        if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat byte=%02h kind=%0d err=%0d last=%0b",
                                      o_out_byte, o_kind, o_error_code, o_last_of_run));
            return;
        end
        want = expected_beats.pop_front();
        beats_seen++;
        if (want.kind == jsu_pkg::KIND_CLOSE) close_beats++;
        if (want.kind == jsu_pkg::KIND_ERROR) begin
            error_beats++;
            err_count[want.err]++;
        end
        if (o_out_byte !== want.data)
            report_mismatch($sformatf("beat %0d byte %02h, want %02h",
                                      beats_seen, o_out_byte, want.data));
        if (o_kind !== want.kind)
            report_mismatch($sformatf("beat %0d kind %0d, want %0d",
                                      beats_seen, o_kind, want.kind));
        if (o_error_code !== want.err)
            report_mismatch($sformatf("beat %0d error code %0d, want %0d",
                                      beats_seen, o_error_code, want.err));
        if (o_last_of_run !== want.last)
            report_mismatch($sformatf("beat %0d last %0b, want %0b",
                                      beats_seen, o_last_of_run, want.last));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_stall) stall_cycles++;
    end

    initial begin : beat_sink
        int gap;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req > 0) begin
                gap = hold_req;
                hold_req = 0;
            end else begin
                gap = burst ? 0 : $urandom_range(0, 7);
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            check_beat();
        end
    end

    initial begin : byte_source
        t_row row;
        bit   hold_done;
        hold_done     = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_text_byte   <= 8'h00;
        i_end_of_text <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            offer_byte(row.text, row.eot, row.typed, mk_beat(row.data, row.kind, row.err));
        end

        while (bytes_sent < $size(dir_rows) + RandomBytes) begin
            if (!hold_done && bytes_sent >= 150) begin
                // long output hold-off while a dense literal keeps coming
                hold_done = 1'b1;
                burst     = 1'b1;
                hold_req  = 90;
                put_byte(CH_QUOTE, 1'b0);
                repeat (40) put_byte(plain_byte(), 1'b0);
                put_byte(CH_QUOTE, 1'b0);
            end else begin
                random_literal();
            end
        end
        i_valid <= 1'b0;
        burst   = 1'b0;

        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (expected_beats.size() != 0)
            report_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));

        $display("Run: %0d source bytes, %0d beats checked (%0d closes, %0d errors), %0d stall cycles",
                 bytes_sent, beats_seen, close_beats, error_beats, stall_cycles);
        $display("Errors by cause: no quote %0d, bad escape %0d, bad hex %0d, unterminated %0d",
                 err_count[jsu_pkg::ERR_NO_QUOTE], err_count[jsu_pkg::ERR_BAD_ESC],
                 err_count[jsu_pkg::ERR_BAD_HEX], err_count[jsu_pkg::ERR_UNTERM]);
        if (mismatches == 0) begin
            $display("json_string_unescape_utf8 test passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("json_string_unescape_utf8 test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Timeout with %0d beats outstanding", expected_beats.size());
        $display("json_string_unescape_utf8 test failed");
        $finish;
    end

endmodule
